[rtl/nvrgb_pkg.sv]
// ---------------------------------------------------------------------------
// nvrgb_pkg
// Shared constants, types and helper functions for the NV12 to RGB565
// converter: register indexes, buffer sizes, colour coefficients and the
// item record that passes from the front part to the back part.
// ---------------------------------------------------------------------------
package nvrgb_pkg;

  // Line buffer depth in pixel pairs and the widths that follow from it.
  localparam int MaxPairs = 1024;
  localparam int ColW     = $clog2(MaxPairs);
  localparam int WidthW   = 11;
  localparam int RowsW    = 16;
  localparam int CfgDataW = 16;
  localparam int CmpW     = (ColW + 1 > WidthW) ? ColW + 1 : WidthW;

  // Queue between the front and back parts.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Colour products and the reciprocal used for the division by 1000.
  // The reciprocal is exact for magnitudes below 2^28 / 544, well above
  // the largest product magnitude (1772 * 128).
  localparam int ProdW    = 20;
  localparam int MagW     = 19;
  localparam int DivShift = 28;
  localparam int RecipW   = 19;
  localparam logic [RecipW-1:0] DivRecip = RecipW'(268436);
  localparam logic signed [ProdW-1:0] CoefRv = ProdW'(1402);
  localparam logic signed [ProdW-1:0] CoefGu = ProdW'(344);
  localparam logic signed [ProdW-1:0] CoefGv = ProdW'(714);
  localparam logic signed [ProdW-1:0] CoefBu = ProdW'(1772);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CfgWidthPairs = 1'b0,
    CfgFrameRows  = 1'b1
  } cfg_idx_t;

  // One pixel pair with its resolved chroma and framing flags.
  typedef struct packed {
    logic [7:0] luma_left;
    logic [7:0] luma_right;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic       row_end;
    logic       frame_end;
  } item_t;

  // Clamp a signed channel value to 0..255.
  function automatic logic [7:0] clamp8(input logic signed [10:0] x);
    logic [7:0] res;
    if (x < 0) begin
      res = 8'd0;
    end else if (x > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  // Pack clamped channels into RGB565.
  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

[rtl/nv12_to_rgb565_converter_core.sv]
// ---------------------------------------------------------------------------
// nv12_to_rgb565_converter_core
// NV12 to RGB565 colour converter, one horizontal pixel pair per item.
// ---------------------------------------------------------------------------
// Usage:
// The input stream carries a 4:2:0 frame in raster order, one pixel pair
// per item. On even rows the item's chroma is used and kept in a line
// buffer; on odd rows the buffered chroma is used and the item's chroma is
// ignored. Each result item carries two RGB565 pixels, with tlast marking
// the last pair of a row and tuser the last pair of the frame.
// The configuration port sets the pairs per row (index 0) and rows per
// frame (index 1). The user must ensure it is written only while the
// block is idle; the block does not enforce this. Throughput is one item
// per clock cycle while the receiver takes results. A result passes the
// line buffer read stage, the queue, the product and division stages and
// the output register. If the receiver stalls, the back pipeline holds,
// the four-entry queue fills and in_tready falls to stop new items.
// Reset clears the row and column counters, the queue and the pipeline and
// sets both registers to one; the line buffer is not cleared.
// ---------------------------------------------------------------------------
module nv12_to_rgb565_converter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [0:0]                     cfg_addr,
  input  logic [nvrgb_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // luma_left[7:0], luma_right[15:8], chroma_u[23:16], chroma_v[31:24]
  input  logic [31:0]                    in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // pixel_left[15:0], pixel_right[31:16]
  output logic [31:0]                    out_tdata,
  output logic                           out_tlast,
  // frame_end[0]
  output logic [0:0]                     out_tuser
);

  logic                        q_push, q_pop, q_not_empty;
  nvrgb_pkg::item_t            q_push_item, q_head_item;
  logic [nvrgb_pkg::QCntW-1:0] q_count;

  // Front part: counters, line buffer and chroma selection.
  nvrgb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_item    (q_push_item)
  );

  // Queue between the two parts.
  nvrgb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (q_head_item),
    .count     (q_count)
  );

  // Back part: colour conversion pipeline and output register.
  nvrgb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_item      (q_head_item),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule

[rtl/nvrgb_front.sv]
// ---------------------------------------------------------------------------
// nvrgb_front
// Accepts pixel pairs, tracks column and row, keeps the chroma line buffer
// and hands each pair, with its chroma and framing flags, to the queue.
// ---------------------------------------------------------------------------
module nvrgb_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [0:0]                     cfg_addr,
  input  logic [nvrgb_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,
  input  logic [nvrgb_pkg::QCntW-1:0]    q_count,
  output logic                           q_push,
  output nvrgb_pkg::item_t               q_item
);

  logic [nvrgb_pkg::WidthW-1:0] width_pairs_r;
  logic [nvrgb_pkg::RowsW-1:0]  frame_rows_r;
  logic [nvrgb_pkg::ColW-1:0]   col_r, col_nxt;
  logic [nvrgb_pkg::RowsW-1:0]  row_r, row_nxt;
  logic [nvrgb_pkg::WidthW-1:0] eff_w;
  logic [nvrgb_pkg::RowsW-1:0]  eff_rows;
  logic                         accept;
  logic                         row_end, frame_end;
  logic [15:0]                  chroma_mem [nvrgb_pkg::MaxPairs];
  logic [15:0]                  mem_rd_r;
  logic                         s1_valid_r;
  logic                         s1_odd_r;
  logic [31:0]                  s1_data_r;
  logic                         s1_row_end_r, s1_frame_end_r;
  logic [15:0]                  chroma_sel;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_pairs_r <= nvrgb_pkg::WidthW'(1);
      frame_rows_r  <= nvrgb_pkg::RowsW'(1);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        nvrgb_pkg::CfgWidthPairs: width_pairs_r <= cfg_wdata[nvrgb_pkg::WidthW-1:0];
        nvrgb_pkg::CfgFrameRows:  frame_rows_r  <= cfg_wdata[nvrgb_pkg::RowsW-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry: width at least one and saturated to the buffer size, rows at least one.
  always_comb begin
    eff_w = width_pairs_r;
    if (width_pairs_r == '0) begin
      eff_w = nvrgb_pkg::WidthW'(1);
    end else if (32'(width_pairs_r) > nvrgb_pkg::MaxPairs) begin
      eff_w = nvrgb_pkg::WidthW'(nvrgb_pkg::MaxPairs);
    end
    eff_rows = (frame_rows_r == '0) ? nvrgb_pkg::RowsW'(1) : frame_rows_r;
  end

  // Space for this item and the one still in the read stage.
  assign in_tready = (32'(q_count) + 32'(s1_valid_r)) < nvrgb_pkg::QDepth;
  assign accept    = in_tvalid && in_tready;

  // Column and row counters.
  always_comb begin
    row_end   = (nvrgb_pkg::CmpW'(col_r) + nvrgb_pkg::CmpW'(1)) >= nvrgb_pkg::CmpW'(eff_w);
    frame_end = row_end && ((17'(row_r) + 17'd1) >= 17'(eff_rows));
    col_nxt   = row_end ? '0 : col_r + nvrgb_pkg::ColW'(1);
    row_nxt   = row_r;
    if (frame_end) begin
      row_nxt = '0;
    end else if (row_end) begin
      row_nxt = row_r + nvrgb_pkg::RowsW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Chroma line buffer: even rows write, odd rows read.
  always_ff @(posedge clk) begin
    if (accept && !row_r[0]) begin
      chroma_mem[col_r] <= in_tdata[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && row_r[0]) begin
      mem_rd_r <= chroma_mem[col_r];
    end
  end

  // Read stage: waits for the buffer read, then pushes into the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_odd_r       <= row_r[0];
      s1_data_r      <= in_tdata;
      s1_row_end_r   <= row_end;
      s1_frame_end_r <= frame_end;
    end
  end

  assign chroma_sel = s1_odd_r ? mem_rd_r : s1_data_r[31:16];

  assign q_push              = s1_valid_r;
  assign q_item.luma_left    = s1_data_r[7:0];
  assign q_item.luma_right   = s1_data_r[15:8];
  assign q_item.chroma_u     = chroma_sel[7:0];
  assign q_item.chroma_v     = chroma_sel[15:8];
  assign q_item.row_end      = s1_row_end_r;
  assign q_item.frame_end    = s1_frame_end_r;

endmodule

[rtl/nvrgb_queue.sv]
// ---------------------------------------------------------------------------
// nvrgb_queue
// Short first-in first-out queue of pixel pair items between the front
// and back parts.
// ---------------------------------------------------------------------------
module nvrgb_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  nvrgb_pkg::item_t            push_item,
  input  logic                        pop,
  output logic                        not_empty,
  output nvrgb_pkg::item_t            head_item,
  output logic [nvrgb_pkg::QCntW-1:0] count
);

  nvrgb_pkg::item_t              slots_r [nvrgb_pkg::QDepth];
  logic [nvrgb_pkg::QPtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [nvrgb_pkg::QCntW-1:0]   count_r;
  logic                          do_pop;

  assign not_empty = (count_r != '0);
  assign head_item = slots_r[rd_ptr_r];
  assign count     = count_r;
  assign do_pop    = pop && not_empty;

  // Storage slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + nvrgb_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + nvrgb_pkg::QPtrW'(1);
      end
      if (push && !do_pop) begin
        count_r <= count_r + nvrgb_pkg::QCntW'(1);
      end else if (!push && do_pop) begin
        count_r <= count_r - nvrgb_pkg::QCntW'(1);
      end
    end
  end

endmodule

[rtl/nvrgb_back.sv]
// ---------------------------------------------------------------------------
// nvrgb_back
// Colour conversion pipeline: chroma products, division by 1000 through a
// reciprocal, luma addition, clamping and RGB565 packing into the output
// register. The whole pipeline holds while the output is stalled.
// ---------------------------------------------------------------------------
module nvrgb_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_not_empty,
  input  nvrgb_pkg::item_t q_item,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,
  output logic             out_tlast,
  output logic [0:0]       out_tuser
);

  logic                               advance;
  logic signed [8:0]                  du, dv;
  logic signed [nvrgb_pkg::ProdW-1:0] du_x, dv_x;

  // Stage 1: chroma products.
  logic                               b1_valid_r;
  logic signed [nvrgb_pkg::ProdW-1:0] b1_pr_r, b1_pg_r, b1_pb_r;
  logic [7:0]                         b1_yl_r, b1_yr_r;
  logic                               b1_row_end_r, b1_frame_end_r;

  // Stage 2: signed quotients.
  logic                               b2_valid_r;
  logic signed [8:0]                  b2_qr_r, b2_qg_r, b2_qb_r;
  logic [7:0]                         b2_yl_r, b2_yr_r;
  logic                               b2_row_end_r, b2_frame_end_r;
  logic signed [8:0]                  qr, qg, qb;

  // Output register.
  logic                               out_valid_r;
  logic [15:0]                        pix_l_r, pix_r_r;
  logic                               row_end_r, frame_end_r;
  logic [15:0]                        pix_l, pix_r;

  // Divide a signed product by 1000, truncating toward zero.
  function automatic logic signed [8:0] div1000(input logic signed [nvrgb_pkg::ProdW-1:0] p);
    logic [nvrgb_pkg::ProdW-1:0]                    mag_full;
    logic [nvrgb_pkg::MagW-1:0]                     mag;
    logic [nvrgb_pkg::MagW+nvrgb_pkg::RecipW-1:0]   prod;
    logic [7:0]                                     q;
    mag_full = p[nvrgb_pkg::ProdW-1] ? nvrgb_pkg::ProdW'(-p) : nvrgb_pkg::ProdW'(p);
    mag      = mag_full[nvrgb_pkg::MagW-1:0];
    prod     = (nvrgb_pkg::MagW + nvrgb_pkg::RecipW)'(mag) *
               (nvrgb_pkg::MagW + nvrgb_pkg::RecipW)'(nvrgb_pkg::DivRecip);
    q        = prod[nvrgb_pkg::DivShift +: 8];
    return p[nvrgb_pkg::ProdW-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  // Convert one pixel from luma and the quotients.
  function automatic logic [15:0] to565(input logic [7:0] y, input logic signed [8:0] qr_i,
                                        input logic signed [8:0] qg_i,
                                        input logic signed [8:0] qb_i);
    logic signed [10:0] ys, r, g, b;
    ys = $signed({3'b000, y});
    r  = ys + 11'(qr_i);
    g  = ys - 11'(qg_i);
    b  = ys + 11'(qb_i);
    return nvrgb_pkg::pack565(nvrgb_pkg::clamp8(r), nvrgb_pkg::clamp8(g),
                              nvrgb_pkg::clamp8(b));
  endfunction

  assign advance = !out_valid_r || out_tready;
  assign q_pop   = advance && q_not_empty;

  // Chroma offsets from the queue head.
  assign du   = $signed({1'b0, q_item.chroma_u}) - 9'sd128;
  assign dv   = $signed({1'b0, q_item.chroma_v}) - 9'sd128;
  assign du_x = nvrgb_pkg::ProdW'(du);
  assign dv_x = nvrgb_pkg::ProdW'(dv);

  // Valid bits of all stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      b2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      b1_valid_r  <= q_not_empty;
      b2_valid_r  <= b1_valid_r;
      out_valid_r <= b2_valid_r;
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      b1_pr_r        <= dv_x * nvrgb_pkg::CoefRv;
      b1_pg_r        <= du_x * nvrgb_pkg::CoefGu + dv_x * nvrgb_pkg::CoefGv;
      b1_pb_r        <= du_x * nvrgb_pkg::CoefBu;
      b1_yl_r        <= q_item.luma_left;
      b1_yr_r        <= q_item.luma_right;
      b1_row_end_r   <= q_item.row_end;
      b1_frame_end_r <= q_item.frame_end;
    end
  end

  // Stage 2 payload.
  assign qr = div1000(b1_pr_r);
  assign qg = div1000(b1_pg_r);
  assign qb = div1000(b1_pb_r);

  always_ff @(posedge clk) begin
    if (advance) begin
      b2_qr_r        <= qr;
      b2_qg_r        <= qg;
      b2_qb_r        <= qb;
      b2_yl_r        <= b1_yl_r;
      b2_yr_r        <= b1_yr_r;
      b2_row_end_r   <= b1_row_end_r;
      b2_frame_end_r <= b1_frame_end_r;
    end
  end

  // Output register payload.
  assign pix_l = to565(b2_yl_r, b2_qr_r, b2_qg_r, b2_qb_r);
  assign pix_r = to565(b2_yr_r, b2_qr_r, b2_qg_r, b2_qb_r);

  always_ff @(posedge clk) begin
    if (advance) begin
      pix_l_r     <= pix_l;
      pix_r_r     <= pix_r;
      row_end_r   <= b2_row_end_r;
      frame_end_r <= b2_frame_end_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {pix_r_r, pix_l_r};
  assign out_tlast  = row_end_r;
  assign out_tuser  = frame_end_r;

endmodule
